/* src/lin_master_frame_builder_defines.svh */
// assertion macros for the lin master frame builder
`ifndef LIN_MASTER_FRAME_BUILDER_DEFINES_SVH
`define LIN_MASTER_FRAME_BUILDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LMFB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmfb check failed");

// next-cycle implication, disabled during reset
`define LMFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmfb check failed");

`endif

/* src/lmfb_pkg.sv */
// shared types, constants and functions of the lin master frame builder
`default_nettype none

package lmfb_pkg;

    localparam int CNT_W = 4;

    localparam logic [7:0] BREAK_BYTE = 8'h00;
    localparam logic [7:0] SYNC_BYTE  = 8'h55;

    // slot positions inside a plan, in emission order
    localparam int SLOT_BREAK = 0;
    localparam int SLOT_SYNC  = 1;
    localparam int SLOT_PID   = 2;
    localparam int SLOT_DATA  = 3;
    localparam int SLOT_CKSUM = 4;
    localparam int SLOTS      = 5;

    typedef enum logic [2:0] {
        KIND_BREAK = 3'd0,
        KIND_SYNC  = 3'd1,
        KIND_PID   = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_CKSUM = 3'd4
    } lmfb_kind_t;

    typedef struct packed {
        logic       cmd;
        logic [5:0] ident;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } lmfb_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        lmfb_kind_t byte_kind;
        logic       overflow;
        logic       end_of_run;
    } lmfb_out_t;

    // bytes one request produces, handed from encoder to emitter
    typedef struct packed {
        logic [SLOTS-1:0] slot_en;
        logic [7:0]       pid;
        logic [7:0]       data;
        logic [7:0]       cksum;
        logic             overflow;
    } lmfb_plan_t;

    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // ones-complement add with end-around carry
    function automatic logic [7:0] ones_add(input logic [7:0] acc, input logic [7:0] v);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, v};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

`default_nettype wire

/* src/lmfb_encoder.sv */
// frame state and per-request byte plan with a one-entry plan buffer
`default_nettype none

module lmfb_encoder #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lmfb_pkg::lmfb_in_t in_item,
    output logic                    plan_valid,
    output lmfb_pkg::lmfb_plan_t    plan,
    input  wire logic               plan_take
);

    localparam logic [lmfb_pkg::CNT_W-1:0] MAX_CNT = lmfb_pkg::CNT_W'(MAX_DATA_BYTES);
    localparam logic [lmfb_pkg::CNT_W-1:0] OVF_CNT = lmfb_pkg::CNT_W'(MAX_DATA_BYTES + 1);

    logic [7:0]                running_sum_reg;
    logic [7:0]                running_sum_next;
    logic                      in_frame_reg;
    logic                      in_frame_next;
    logic [lmfb_pkg::CNT_W-1:0] bytes_sent_reg;
    logic [lmfb_pkg::CNT_W-1:0] bytes_sent_next;
    logic                      plan_valid_reg;
    logic                      plan_valid_next;
    lmfb_pkg::lmfb_plan_t      plan_reg;
    lmfb_pkg::lmfb_plan_t      plan_next;

    logic                      accept;
    logic [7:0]                pid;
    logic                      start;
    logic [7:0]                sum_base;
    logic [lmfb_pkg::CNT_W-1:0] cnt_base;
    logic                      take_data;
    logic [7:0]                sum_data;
    logic [lmfb_pkg::CNT_W-1:0] cnt_data;
    logic                      hdr;
    logic                      close;

    assign in_ready   = !plan_valid_reg || plan_take;
    assign accept     = in_valid && in_ready;
    assign plan_valid = plan_valid_reg;
    assign plan       = plan_reg;

    always_comb
    begin
        pid       = lmfb_pkg::protect_id(in_item.ident);
        start     = in_item.cmd && (in_item.first_byte || !in_frame_reg);
        sum_base  = start ? pid : running_sum_reg;
        cnt_base  = start ? '0 : bytes_sent_reg;
        take_data = in_item.cmd && (cnt_base < MAX_CNT);
        sum_data  = take_data ? lmfb_pkg::ones_add(sum_base, in_item.data_byte) : sum_base;
        cnt_data  = take_data ? cnt_base + 1'b1 : OVF_CNT;
        hdr       = !in_item.cmd || start;
        close     = !in_item.cmd || in_item.last_byte;

        plan_next.slot_en                      = '0;
        plan_next.slot_en[lmfb_pkg::SLOT_BREAK] = hdr;
        plan_next.slot_en[lmfb_pkg::SLOT_SYNC]  = hdr;
        plan_next.slot_en[lmfb_pkg::SLOT_PID]   = hdr;
        plan_next.slot_en[lmfb_pkg::SLOT_DATA]  = take_data;
        plan_next.slot_en[lmfb_pkg::SLOT_CKSUM] = in_item.cmd && in_item.last_byte;
        plan_next.pid      = pid;
        plan_next.data     = in_item.data_byte;
        plan_next.cksum    = ~sum_data;
        plan_next.overflow = cnt_data > MAX_CNT;
    end

    always_comb
    begin
        running_sum_next = running_sum_reg;
        in_frame_next    = in_frame_reg;
        bytes_sent_next  = bytes_sent_reg;
        if (accept)
        begin
            if (close)
            begin
                running_sum_next = '0;
                in_frame_next    = 1'b0;
                bytes_sent_next  = '0;
            end
            else
            begin
                running_sum_next = sum_data;
                in_frame_next    = 1'b1;
                bytes_sent_next  = cnt_data;
            end
        end
    end

    // a dropped byte without a checksum produces nothing
    always_comb
    begin
        plan_valid_next = plan_valid_reg && !plan_take;
        if (accept && (plan_next.slot_en != '0))
        begin
            plan_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            in_frame_reg    <= 1'b0;
            bytes_sent_reg  <= '0;
            plan_valid_reg  <= 1'b0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
            in_frame_reg    <= in_frame_next;
            bytes_sent_reg  <= bytes_sent_next;
            plan_valid_reg  <= plan_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plan_reg <= plan_next;
        end
    end

endmodule

`default_nettype wire

/* src/lmfb_emitter.sv */
// walks a byte plan one slot per cycle into the output register while out_ready allows
`default_nettype none

module lmfb_emitter (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 plan_valid,
    input  wire lmfb_pkg::lmfb_plan_t plan,
    output logic                      plan_take,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lmfb_pkg::lmfb_out_t       out_item
);

    logic [lmfb_pkg::SLOTS-1:0] pending_reg;
    logic [lmfb_pkg::SLOTS-1:0] pending_next;
    lmfb_pkg::lmfb_plan_t       cur_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    lmfb_pkg::lmfb_out_t        out_item_reg;
    lmfb_pkg::lmfb_out_t        out_item_next;

    logic                       issue;
    logic [lmfb_pkg::SLOTS-1:0] sel;
    logic [lmfb_pkg::SLOTS-1:0] remaining;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        sel       = pending_reg & (~pending_reg + 1'b1);
        remaining = pending_reg & ~sel;
        issue     = (pending_reg != '0) && (!out_valid_reg || out_ready);
        plan_take = plan_valid && ((pending_reg == '0) || (issue && (remaining == '0)));
    end

    always_comb
    begin
        pending_next = issue ? remaining : pending_reg;
        if (plan_take)
        begin
            pending_next = plan.slot_en;
        end
    end

    always_comb
    begin
        out_item_next.out_byte   = lmfb_pkg::BREAK_BYTE;
        out_item_next.byte_kind  = lmfb_pkg::KIND_BREAK;
        out_item_next.overflow   = 1'b0;
        out_item_next.end_of_run = remaining == '0;
        if (sel[lmfb_pkg::SLOT_SYNC])
        begin
            out_item_next.out_byte  = lmfb_pkg::SYNC_BYTE;
            out_item_next.byte_kind = lmfb_pkg::KIND_SYNC;
        end
        else if (sel[lmfb_pkg::SLOT_PID])
        begin
            out_item_next.out_byte  = cur_reg.pid;
            out_item_next.byte_kind = lmfb_pkg::KIND_PID;
        end
        else if (sel[lmfb_pkg::SLOT_DATA])
        begin
            out_item_next.out_byte  = cur_reg.data;
            out_item_next.byte_kind = lmfb_pkg::KIND_DATA;
        end
        else if (sel[lmfb_pkg::SLOT_CKSUM])
        begin
            out_item_next.out_byte  = cur_reg.cksum;
            out_item_next.byte_kind = lmfb_pkg::KIND_CKSUM;
            out_item_next.overflow  = cur_reg.overflow;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (plan_take)
        begin
            cur_reg <= plan;
        end
        if (issue)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

`default_nettype wire

/* src/lin_master_frame_builder.sv */
// top level of the lin master frame builder
// A request is taken into the encoder, which updates the frame state and the enhanced
// checksum at once and stores the list of bytes the request causes in a one-entry plan
// buffer. The emitter then sends those bytes one per cycle while out_ready allows,
// through a registered output: a header request gives three bytes, a data byte one,
// the first byte of a frame four, a frame's last byte one more for the checksum, up
// to five in all, and a dropped excess byte without a checksum gives none. A new
// request is taken while the previous one is still being sent, whenever the plan
// buffer is free or is being handed to the emitter in that cycle, so with out_ready
// held high the output runs at one byte per cycle with no gap between requests.
`default_nettype none
`include "lin_master_frame_builder_defines.svh"

module lin_master_frame_builder #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lmfb_pkg::lmfb_in_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lmfb_pkg::lmfb_out_t      out_item
);

    logic                 plan_valid;
    logic                 plan_take;
    lmfb_pkg::lmfb_plan_t plan;

    lmfb_encoder #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_encoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_take  (plan_take)
    );

    lmfb_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_take  (plan_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    // sync byte is always the fixed pattern
    `LMFB_ASSERT_SAME(a_sync_value,
        out_valid && (out_item.byte_kind == lmfb_pkg::KIND_SYNC),
        out_item.out_byte == lmfb_pkg::SYNC_BYTE)

    // overflow only on a checksum
    `LMFB_ASSERT_SAME(a_ovf_cksum_only,
        out_valid && (out_item.byte_kind != lmfb_pkg::KIND_CKSUM),
        !out_item.overflow)

    // a break never ends a request
    `LMFB_ASSERT_SAME(a_break_not_last,
        out_valid && (out_item.byte_kind == lmfb_pkg::KIND_BREAK),
        !out_item.end_of_run)

    // sync follows a taken break in the next cycle
    `LMFB_ASSERT_NEXT(a_break_then_sync,
        out_valid && out_ready && (out_item.byte_kind == lmfb_pkg::KIND_BREAK),
        out_valid && (out_item.byte_kind == lmfb_pkg::KIND_SYNC))

endmodule

`default_nettype wire

/* sim/lin_master_frame_builder_tb.sv */
// self-checking testbench for the lin master frame builder with its own frame predictor
module lin_master_frame_builder_tb;

    localparam int FRAME_BYTES_MAX = 8;
    localparam int RAND_ITEMS_PER_PHASE = 105;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    lmfb_pkg::lmfb_in_t  in_item;
    logic                out_valid;
    logic                out_ready;
    lmfb_pkg::lmfb_out_t out_item;

    // predictor state
    logic [7:0] sum_acc;
    logic       frame_open;
    logic [3:0] data_cnt;

    lmfb_pkg::lmfb_out_t pending_bytes[$];
    lmfb_pkg::lmfb_out_t want;

    int idle_pct;
    int stall_pct;
    int err_count;
    int sent_count;
    int checked_count;
    int frames_closed;
    int frames_overflowed;

    lin_master_frame_builder #(
        .MAX_DATA_BYTES(FRAME_BYTES_MAX)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic lmfb_pkg::lmfb_in_t lin_req(input logic cmd, input logic [5:0] ident,
                                                   input logic [7:0] data, input logic first,
                                                   input logic last);
        lmfb_pkg::lmfb_in_t it;
        it.cmd        = cmd;
        it.ident      = ident;
        it.data_byte  = data;
        it.first_byte = first;
        it.last_byte  = last;
        return it;
    endfunction

    function automatic void queue_byte(input logic [7:0] v, input lmfb_pkg::lmfb_kind_t k,
                                       input logic ovf);
        lmfb_pkg::lmfb_out_t b;
        b.out_byte   = v;
        b.byte_kind  = k;
        b.overflow   = ovf;
        b.end_of_run = 1'b0;
        pending_bytes.push_back(b);
    endfunction

    function automatic void queue_header(input logic [7:0] pid);
        queue_byte(lmfb_pkg::BREAK_BYTE, lmfb_pkg::KIND_BREAK, 1'b0);
        queue_byte(lmfb_pkg::SYNC_BYTE, lmfb_pkg::KIND_SYNC, 1'b0);
        queue_byte(pid, lmfb_pkg::KIND_PID, 1'b0);
    endfunction

    // bytes that one accepted request puts on the line
    function automatic void predict_frame_bytes(input lmfb_pkg::lmfb_in_t it);
        logic [7:0]          pid;
        logic [8:0]          s9;
        int                  n_before;
        lmfb_pkg::lmfb_out_t tail;
        n_before = pending_bytes.size();
        pid = {~^(it.ident & 6'b111010), ^(it.ident & 6'b010111), it.ident};
        if (!it.cmd)
        begin
            queue_header(pid);
            sum_acc    = 8'd0;
            frame_open = 1'b0;
            data_cnt   = 4'd0;
        end
        else
        begin
            if (it.first_byte || !frame_open)
            begin
                queue_header(pid);
                sum_acc    = pid;
                frame_open = 1'b1;
                data_cnt   = 4'd0;
            end
            if (data_cnt < FRAME_BYTES_MAX)
            begin
                queue_byte(it.data_byte, lmfb_pkg::KIND_DATA, 1'b0);
                s9 = {1'b0, sum_acc} + {1'b0, it.data_byte};
                sum_acc = (s9 > 9'd255) ? 8'(s9 - 9'd255) : s9[7:0];
                data_cnt = data_cnt + 4'd1;
            end
            else
            begin
                data_cnt = 4'(FRAME_BYTES_MAX + 1);
            end
            if (it.last_byte)
            begin
                queue_byte(~sum_acc, lmfb_pkg::KIND_CKSUM, data_cnt > FRAME_BYTES_MAX);
                frames_closed++;
                if (data_cnt > FRAME_BYTES_MAX)
                    frames_overflowed++;
                sum_acc    = 8'd0;
                frame_open = 1'b0;
                data_cnt   = 4'd0;
            end
        end
        if (pending_bytes.size() > n_before)
        begin
            tail = pending_bytes.pop_back();
            tail.end_of_run = 1'b1;
            pending_bytes.push_back(tail);
        end
    endfunction

    // call at a rising edge; returns at the edge where the request is taken
    task automatic send_item(input lmfb_pkg::lmfb_in_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_frame_bytes(it);
        sent_count++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic void report_mismatch(input string field, input int exp_v,
                                            input int got_v);
        err_count++;
        if (err_count <= 60)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            checked_count++;
            if (pending_bytes.size() == 0)
            begin
                err_count++;
                if (err_count <= 60)
                    $display("%0t: unexpected output, expected nothing, got %0h", $time,
                             out_item);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_item.out_byte !== want.out_byte)
                    report_mismatch("out_byte", want.out_byte, out_item.out_byte);
                if (out_item.byte_kind !== want.byte_kind)
                    report_mismatch("byte_kind", want.byte_kind, out_item.byte_kind);
                if (out_item.overflow !== want.overflow)
                    report_mismatch("overflow", want.overflow, out_item.overflow);
                if (out_item.end_of_run !== want.end_of_run)
                    report_mismatch("end_of_run", want.end_of_run, out_item.end_of_run);
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic test_header_requests();
        send_item(lin_req(1'b0, 6'h00, 8'($urandom), 1'($urandom), 1'($urandom)));
        send_item(lin_req(1'b0, 6'h3f, 8'($urandom), 1'($urandom), 1'($urandom)));
    endtask

    task automatic test_single_byte_frames();
        send_item(lin_req(1'b1, 6'h00, 8'hff, 1'b1, 1'b1));
        send_item(lin_req(1'b1, 6'h3f, 8'h00, 1'b1, 1'b1));
    endtask

    // full frame of 0xff bytes, then two excess bytes, both dropped, the second closing it
    task automatic test_overflow_frame();
        int k;
        for (k = 0; k < 10; k++)
            send_item(lin_req(1'b1, 6'h3f, 8'hff, k == 0, k == 9));
    endtask

    task automatic test_abandoned_frames();
        send_item(lin_req(1'b1, 6'h11, 8'h80, 1'b1, 1'b0));
        send_item(lin_req(1'b0, 6'h3c, 8'h00, 1'b0, 1'b0));
        send_item(lin_req(1'b1, 6'h22, 8'h01, 1'b1, 1'b0));
        send_item(lin_req(1'b1, 6'h22, 8'h00, 1'b0, 1'b0));
        send_item(lin_req(1'b1, 6'h33, 8'hfe, 1'b1, 1'b1));
        // data with no open frame and no first mark
        send_item(lin_req(1'b1, 6'h2f, 8'haa, 1'b0, 1'b0));
        send_item(lin_req(1'b1, 6'h15, 8'h55, 1'b0, 1'b1));
    endtask

    task automatic test_random_traffic(input int n_items);
        int                 sent;
        int                 pick;
        int                 len;
        int                 k;
        logic [5:0]         frame_id;
        lmfb_pkg::lmfb_in_t it;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                it = lmfb_pkg::lmfb_in_t'($bits(lmfb_pkg::lmfb_in_t)'($urandom));
                it.cmd = 1'b0;
                send_item(it);
                sent++;
            end
            else if (pick < 18)
            begin
                send_item(lmfb_pkg::lmfb_in_t'($bits(lmfb_pkg::lmfb_in_t)'($urandom)));
                sent++;
            end
            else
            begin
                len = (pick < 30) ? $urandom_range(9, 11) : $urandom_range(1, 8);
                frame_id = 6'($urandom);
                for (k = 0; k < len; k++)
                begin
                    it.cmd        = 1'b1;
                    it.ident      = (k == 0) ? frame_id : 6'($urandom);
                    it.data_byte  = 8'($urandom);
                    it.first_byte = (k == 0);
                    it.last_byte  = (k == len - 1) && ($urandom_range(19) != 0);
                    send_item(it);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        err_count         = 0;
        sent_count        = 0;
        checked_count     = 0;
        frames_closed     = 0;
        frames_overflowed = 0;
        idle_pct          = 0;
        stall_pct         = 0;
        sum_acc           = 8'd0;
        frame_open        = 1'b0;
        data_cnt          = 4'd0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        out_ready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_requests();
        test_single_byte_frames();
        test_overflow_frame();
        test_abandoned_frames();
        wait_for_drain();

        idle_pct  = 0;
        stall_pct = 0;
        test_random_traffic(RAND_ITEMS_PER_PHASE);
        wait_for_drain();
        idle_pct  = 81;
        stall_pct = 0;
        test_random_traffic(RAND_ITEMS_PER_PHASE);
        wait_for_drain();
        idle_pct  = 0;
        stall_pct = 81;
        test_random_traffic(RAND_ITEMS_PER_PHASE);
        wait_for_drain();
        idle_pct  = 20;
        stall_pct = 20;
        test_random_traffic(RAND_ITEMS_PER_PHASE);
        wait_for_drain();

        $display("sent %0d requests and checked %0d output bytes", sent_count, checked_count);
        $display("%0d frames closed with a checksum, %0d of them with dropped bytes",
                 frames_closed, frames_overflowed);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d output bytes still pending", pending_bytes.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
